### rtl/hht_pkg.sv
// ----------------------------------------------------------------------------
// hht_pkg: shared types and constants of the heartbeat host table
// Table size, entry layout, command, status and counter operation codes,
// memory request bundle and sequencer states.
// ----------------------------------------------------------------------------
package hht_pkg;

  localparam int CAPACITY    = 32;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int USED_W      = $clog2(CAPACITY + 1);
  localparam int HALF_W      = 64;
  localparam int CNT_W       = 8;
  localparam int INDEX_OUT_W = 6;
  localparam int USED_OUT_W  = 6;
  localparam int IN_TDATA_W  = 128;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 152;
  localparam int OUT_TUSER_W = 4;

  typedef logic signed [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    CMD_ADD      = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_PING     = 3'd2,
    CMD_ADD_PING = 3'd3,
    CMD_REPLY    = 3'd4,
    CMD_SWEEP    = 3'd5,
    CMD_LIST     = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    ST_ADDED     = 4'd0,
    ST_PRESENT   = 4'd1,
    ST_FULL      = 4'd2,
    ST_REMOVED   = 4'd3,
    ST_NOT_FOUND = 4'd4,
    ST_COUNTED   = 4'd5,
    ST_SILENT    = 4'd6,
    ST_ENTRY     = 4'd7,
    ST_DONE      = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_UP,
    CNT_DOWN
  } cnt_op_t;

  typedef struct packed {
    logic [HALF_W-1:0] high;
    logic [HALF_W-1:0] low;
    cnt_t              cnt;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_EMIT,
    S_DUMP_RD,
    S_DUMP_CHK
  } state_t;

endpackage

### rtl/hht_entry_ram.sv
// ----------------------------------------------------------------------------
// hht_entry_ram: host entry store
// One write port and one registered read port; each entry holds the 128-bit
// host address and its echo counter.
// ----------------------------------------------------------------------------
module hht_entry_ram
  import hht_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rd_data
);

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/hht_match_unit.sv
// ----------------------------------------------------------------------------
// hht_match_unit: shared compare and counter unit
// Compares the search key with the entry read from the store and produces
// the saturated up or down count of a counter.
// ----------------------------------------------------------------------------
module hht_match_unit
  import hht_pkg::*;
(
  input  logic [HALF_W-1:0] key_high,
  input  logic [HALF_W-1:0] key_low,
  input  entry_t            entry,
  input  cnt_t              cnt_in,
  input  cnt_op_t           op,
  output logic              match,
  output logic              cnt_nonzero,
  output cnt_t              cnt_out
);

  localparam cnt_t CNT_MAX = cnt_t'({1'b0, {(CNT_W-1){1'b1}}});
  localparam cnt_t CNT_MIN = cnt_t'({1'b1, {(CNT_W-1){1'b0}}});

  assign match       = (entry.high == key_high) && (entry.low == key_low);
  assign cnt_nonzero = (cnt_in != '0);

  always_comb begin
    case (op)
      CNT_UP:   cnt_out = (cnt_in == CNT_MAX) ? cnt_in : cnt_t'(cnt_in + cnt_t'(1));
      CNT_DOWN: cnt_out = (cnt_in == CNT_MIN) ? cnt_in : cnt_t'(cnt_in - cnt_t'(1));
      default:  cnt_out = cnt_in;
    endcase
  end

endmodule

### rtl/heartbeat_host_table.sv
// ----------------------------------------------------------------------------
// heartbeat_host_table: liveness table of hosts with echo counters
// Sequencer that walks the entry store through one compare and counter unit.
// ----------------------------------------------------------------------------
// One command word is taken at a time; in_tready is high only while the
// sequencer idles. Lookups read the store one entry per cycle; remove then
// moves every later entry down by one slot. Sweep and list read and check
// the stored entries one at a time and wait while the output side stalls.
// The result words sit in an output register, so the next command is taken
// while the last result waits. The address store comes up undefined and is
// only read below the fill count; every counter below that count was
// written by an insert, so the counters need no clearing after reset.
module heartbeat_host_table
  import hht_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // address_high [63:0], address_low [127:64]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command [2:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // entry_index [5:0], host_high [69:6], host_low [133:70],
  // pending_echoes [141:134], entries_in_use [147:142], zero [151:148]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status [3:0]
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast
);

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [HALF_W-1:0] key_high_r, key_high_nxt;
  logic [HALF_W-1:0] key_low_r, key_low_nxt;
  logic [USED_W-1:0] idx_r, idx_nxt;
  logic              rvld_r, rvld_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_slot_r, res_slot_nxt;
  cnt_t              res_cnt_r, res_cnt_nxt;

  logic                  out_valid_r;
  status_t               out_status_r, out_status_nxt;
  logic [INDEX_OUT_W-1:0] out_index_r, out_index_nxt;
  logic [HALF_W-1:0]     out_high_r, out_high_nxt;
  logic [HALF_W-1:0]     out_low_r, out_low_nxt;
  cnt_t                  out_cnt_r, out_cnt_nxt;
  logic [USED_OUT_W-1:0] out_used_r;
  logic                  out_last_r, out_last_nxt;
  logic                  out_load;
  logic                  out_free;

  ram_req_t          ram_req;
  entry_t            rd_data;
  cnt_t              alu_cnt_in;
  cnt_op_t           alu_op;
  logic              alu_match;
  logic              alu_nonzero;
  cnt_t              alu_cnt_out;
  logic              hit;
  logic [USED_W-1:0] scan_slot;
  logic [USED_W-1:0] shift_wa;
  cmd_t              in_cmd;

  hht_entry_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  hht_match_unit u_unit (
    .key_high    (key_high_r),
    .key_low     (key_low_r),
    .entry       (rd_data),
    .cnt_in      (alu_cnt_in),
    .op          (alu_op),
    .match       (alu_match),
    .cnt_nonzero (alu_nonzero),
    .cnt_out     (alu_cnt_out)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign hit       = rvld_r && alu_match;
  // read data lags the read address by one entry
  assign scan_slot = idx_r - USED_W'(1);
  assign shift_wa  = idx_r - USED_W'(2);
  assign in_cmd    = cmd_t'(in_tuser[2:0]);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_high_nxt   = key_high_r;
    key_low_nxt    = key_low_r;
    idx_nxt        = idx_r;
    rvld_nxt       = rvld_r;
    used_nxt       = used_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_cnt_nxt    = res_cnt_r;
    ram_req        = '0;
    alu_cnt_in     = rd_data.cnt;
    alu_op         = CNT_HOLD;
    out_load       = 1'b0;
    out_status_nxt = ST_DONE;
    out_index_nxt  = '0;
    out_high_nxt   = '0;
    out_low_nxt    = '0;
    out_cnt_nxt    = '0;
    out_last_nxt   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = in_cmd;
          key_high_nxt = in_tdata[HALF_W-1:0];
          key_low_nxt  = in_tdata[2*HALF_W-1:HALF_W];
          idx_nxt      = '0;
          rvld_nxt     = 1'b0;
          if (in_tuser[2:0] inside {CMD_ADD, CMD_REMOVE, CMD_PING, CMD_ADD_PING,
                                    CMD_REPLY}) begin
            state_nxt = S_SCAN;
          end else if (in_tuser[2:0] inside {CMD_SWEEP, CMD_LIST}) begin
            state_nxt = S_DUMP_RD;
          end else begin
            res_status_nxt = ST_DONE;
            res_slot_nxt   = '0;
            res_cnt_nxt    = '0;
            state_nxt      = S_EMIT;
          end
        end
      end

      S_SCAN: begin
        alu_cnt_in = hit ? rd_data.cnt : cnt_t'(0);
        if (cmd_r inside {CMD_PING, CMD_ADD_PING}) begin
          alu_op = CNT_UP;
        end else if (cmd_r == CMD_REPLY && hit) begin
          alu_op = CNT_DOWN;
        end
        if (hit) begin
          res_slot_nxt = scan_slot[IDX_W-1:0];
          case (cmd_r)
            CMD_ADD: begin
              res_status_nxt = ST_PRESENT;
              res_cnt_nxt    = rd_data.cnt;
              state_nxt      = S_EMIT;
            end
            CMD_REMOVE: begin
              // idx already points at the entry after the hit
              res_status_nxt = ST_REMOVED;
              res_cnt_nxt    = rd_data.cnt;
              rvld_nxt       = 1'b0;
              state_nxt      = S_SHIFT;
            end
            default: begin
              ram_req.we     = 1'b1;
              ram_req.waddr  = scan_slot[IDX_W-1:0];
              ram_req.wdata  = '{high: key_high_r, low: key_low_r, cnt: alu_cnt_out};
              res_status_nxt = ST_COUNTED;
              res_cnt_nxt    = alu_cnt_out;
              state_nxt      = S_EMIT;
            end
          endcase
        end else if (idx_r >= used_r) begin
          state_nxt = S_EMIT;
          if (cmd_r == CMD_REMOVE || cmd_r == CMD_PING) begin
            res_status_nxt = ST_NOT_FOUND;
            res_slot_nxt   = '0;
            res_cnt_nxt    = '0;
          end else if (used_r >= USED_W'(CAPACITY)) begin
            res_status_nxt = ST_FULL;
            res_slot_nxt   = '0;
            res_cnt_nxt    = '0;
          end else begin
            ram_req.we     = 1'b1;
            ram_req.waddr  = used_r[IDX_W-1:0];
            ram_req.wdata  = '{high: key_high_r, low: key_low_r, cnt: alu_cnt_out};
            used_nxt       = used_r + USED_W'(1);
            res_status_nxt = (cmd_r == CMD_ADD_PING) ? ST_COUNTED : ST_ADDED;
            res_slot_nxt   = used_r[IDX_W-1:0];
            res_cnt_nxt    = alu_cnt_out;
          end
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_r[IDX_W-1:0];
          idx_nxt       = idx_r + USED_W'(1);
          rvld_nxt      = 1'b1;
        end
      end

      S_SHIFT: begin
        if (rvld_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = shift_wa[IDX_W-1:0];
          ram_req.wdata = rd_data;
        end
        if (idx_r < used_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_r[IDX_W-1:0];
          idx_nxt       = idx_r + USED_W'(1);
          rvld_nxt      = 1'b1;
        end else begin
          rvld_nxt = 1'b0;
          if (!rvld_r) begin
            used_nxt  = used_r - USED_W'(1);
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = INDEX_OUT_W'(res_slot_r);
          out_high_nxt   = (res_status_r == ST_DONE) ? '0 : key_high_r;
          out_low_nxt    = (res_status_r == ST_DONE) ? '0 : key_low_r;
          out_cnt_nxt    = res_cnt_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_DUMP_RD: begin
        if (idx_r < used_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_r[IDX_W-1:0];
          state_nxt     = S_DUMP_CHK;
        end else begin
          res_status_nxt = ST_DONE;
          res_slot_nxt   = '0;
          res_cnt_nxt    = '0;
          state_nxt      = S_EMIT;
        end
      end

      S_DUMP_CHK: begin
        if (cmd_r == CMD_LIST || alu_nonzero) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_status_nxt = (cmd_r == CMD_SWEEP) ? ST_SILENT : ST_ENTRY;
            out_index_nxt  = INDEX_OUT_W'(idx_r);
            out_high_nxt   = rd_data.high;
            out_low_nxt    = rd_data.low;
            out_cnt_nxt    = rd_data.cnt;
            out_last_nxt   = 1'b0;
            if (cmd_r == CMD_SWEEP) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = idx_r[IDX_W-1:0];
              ram_req.wdata = '{high: rd_data.high, low: rd_data.low, cnt: cnt_t'(0)};
            end
            idx_nxt   = idx_r + USED_W'(1);
            state_nxt = S_DUMP_RD;
          end
        end else begin
          idx_nxt   = idx_r + USED_W'(1);
          state_nxt = S_DUMP_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      rvld_r      <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rvld_r      <= rvld_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_high_r   <= key_high_nxt;
    key_low_r    <= key_low_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_cnt_r    <= res_cnt_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_index_r  <= out_index_nxt;
      out_high_r   <= out_high_nxt;
      out_low_r    <= out_low_nxt;
      out_cnt_r    <= out_cnt_nxt;
      // fill count of the step: it no longer moves once a result goes out
      out_used_r   <= USED_OUT_W'(used_r);
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_used_r, out_cnt_r, out_low_r, out_high_r, out_index_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/hht_checker.sv
// ----------------------------------------------------------------------------
// hht_checker: port-level checks of the heartbeat host table
// Watches the result channel for stalled words, fill count range and the
// shape of done, entry and silent words.
// ----------------------------------------------------------------------------
module hht_checker
  import hht_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser,
  input logic                   out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[147:142] <= USED_OUT_W'(CAPACITY))
    else $error("entries in use beyond table size");

  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_DONE |-> out_tlast && out_tdata[141:0] == '0)
    else $error("done word not last or not zero");

  a_dump_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_SILENT || out_tuser == ST_ENTRY) |-> !out_tlast)
    else $error("entry or silent word marked last");

  a_silent_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_SILENT |-> out_tdata[141:134] != '0)
    else $error("silent word with zero count");

endmodule

bind heartbeat_host_table hht_checker u_hht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

### tb/host_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// host_table_checker: result predictor and comparator for heartbeat_host_table
// Keeps its own copy of the host table and follows every accepted command
// word. It queues the result words the command should produce and compares
// each accepted result word, field by field, with the oldest one queued.
// ----------------------------------------------------------------------------
module host_table_checker
  import hht_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // address_high [63:0], address_low [127:64]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command [2:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // entry_index [5:0], host_high [69:6], host_low [133:70],
  // pending_echoes [141:134], entries_in_use [147:142], zero [151:148]
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  // status [3:0]
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   out_tlast,
  output int unsigned            mismatches,
  output int unsigned            words_pending,
  output int unsigned            words_checked,
  output logic [8:0]             status_seen
);

  typedef struct {
    status_t                status;
    logic [INDEX_OUT_W-1:0] slot;
    logic [HALF_W-1:0]      host_high;
    logic [HALF_W-1:0]      host_low;
    cnt_t                   echoes;
    logic [USED_OUT_W-1:0]  in_use;
    logic                   last;
  } result_word_t;

  logic [HALF_W-1:0] table_high   [CAPACITY];
  logic [HALF_W-1:0] table_low    [CAPACITY];
  cnt_t              table_echoes [CAPACITY];
  int                hosts = 0;
  result_word_t      awaited_words [$];
  int unsigned       fail_count = 0;
  int unsigned       check_count = 0;
  logic [8:0]        seen_mask = '0;

  function automatic int find_host(logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo);
    for (int i = 0; i < hosts; i++) begin
      if (table_high[i] == hi && table_low[i] == lo) return i;
    end
    return -1;
  endfunction

  function automatic cnt_t count_up(cnt_t c);
    return (c == 8'sh7f) ? c : cnt_t'(c + 8'sd1);
  endfunction

  function automatic cnt_t count_down(cnt_t c);
    return (c == 8'sh80) ? c : cnt_t'(c - 8'sd1);
  endfunction

  // returns the host's slot, or -1 when the table has no room
  function automatic int insert_host(logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo,
                                     output status_t st);
    int slot;
    slot = find_host(hi, lo);
    if (slot >= 0) begin
      st = ST_PRESENT;
      return slot;
    end
    if (hosts >= CAPACITY) begin
      st = ST_FULL;
      return -1;
    end
    slot = hosts;
    table_high[slot]   = hi;
    table_low[slot]    = lo;
    table_echoes[slot] = '0;
    hosts++;
    st = ST_ADDED;
    return slot;
  endfunction

  function automatic void queue_word(status_t st, int slot, logic [HALF_W-1:0] hi,
                                     logic [HALF_W-1:0] lo, cnt_t echoes);
    result_word_t w;
    w.status    = st;
    w.slot      = INDEX_OUT_W'(slot);
    w.host_high = hi;
    w.host_low  = lo;
    w.echoes    = echoes;
    w.in_use    = '0;
    w.last      = 1'b0;
    awaited_words.push_back(w);
  endfunction

  function automatic void apply_command(logic [IN_TUSER_W-1:0] cmd,
                                        logic [HALF_W-1:0] hi, logic [HALF_W-1:0] lo);
    int      first;
    int      slot;
    status_t st;
    cnt_t    old;
    first = awaited_words.size();
    case (cmd)
      CMD_ADD: begin
        slot = insert_host(hi, lo, st);
        if (slot < 0) queue_word(st, 0, hi, lo, '0);
        else queue_word(st, slot, hi, lo, table_echoes[slot]);
      end
      CMD_REMOVE: begin
        slot = find_host(hi, lo);
        if (slot < 0) begin
          queue_word(ST_NOT_FOUND, 0, hi, lo, '0);
        end else begin
          old = table_echoes[slot];
          // later entries close the gap
          for (int j = slot; j + 1 < hosts; j++) begin
            table_high[j]   = table_high[j+1];
            table_low[j]    = table_low[j+1];
            table_echoes[j] = table_echoes[j+1];
          end
          hosts--;
          queue_word(ST_REMOVED, slot, hi, lo, old);
        end
      end
      CMD_PING: begin
        slot = find_host(hi, lo);
        if (slot < 0) begin
          queue_word(ST_NOT_FOUND, 0, hi, lo, '0);
        end else begin
          table_echoes[slot] = count_up(table_echoes[slot]);
          queue_word(ST_COUNTED, slot, hi, lo, table_echoes[slot]);
        end
      end
      CMD_ADD_PING: begin
        slot = insert_host(hi, lo, st);
        if (slot < 0) begin
          queue_word(st, 0, hi, lo, '0);
        end else begin
          table_echoes[slot] = count_up(table_echoes[slot]);
          queue_word(ST_COUNTED, slot, hi, lo, table_echoes[slot]);
        end
      end
      CMD_REPLY: begin
        slot = find_host(hi, lo);
        if (slot >= 0) begin
          table_echoes[slot] = count_down(table_echoes[slot]);
          queue_word(ST_COUNTED, slot, hi, lo, table_echoes[slot]);
        end else begin
          // an unknown host that answers gets a fresh entry
          slot = insert_host(hi, lo, st);
          queue_word(st, (slot < 0) ? 0 : slot, hi, lo, '0);
        end
      end
      CMD_SWEEP: begin
        for (int i = 0; i < hosts; i++) begin
          if (table_echoes[i] != 0) begin
            queue_word(ST_SILENT, i, table_high[i], table_low[i], table_echoes[i]);
            table_echoes[i] = '0;
          end
        end
        queue_word(ST_DONE, 0, '0, '0, '0);
      end
      CMD_LIST: begin
        for (int i = 0; i < hosts; i++) begin
          queue_word(ST_ENTRY, i, table_high[i], table_low[i], table_echoes[i]);
        end
        queue_word(ST_DONE, 0, '0, '0, '0);
      end
      default: queue_word(ST_DONE, 0, '0, '0, '0);
    endcase
    for (int i = first; i < awaited_words.size(); i++) begin
      awaited_words[i].in_use = USED_OUT_W'(hosts);
    end
    awaited_words[awaited_words.size()-1].last = 1'b1;
  endfunction

  function automatic void compare_field(string name, logic [HALF_W-1:0] want,
                                        logic [HALF_W-1:0] got);
    if (want !== got) begin
      $display("%0t checker: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    result_word_t w;
    if (awaited_words.size() == 0) begin
      $display("%0t checker: result word with none expected, expected nothing, got %0h %0h %0b",
               $time, out_tuser, out_tdata, out_tlast);
      fail_count++;
      return;
    end
    w = awaited_words.pop_front();
    compare_field("status", w.status, out_tuser);
    compare_field("entry_index", w.slot, out_tdata[5:0]);
    compare_field("host_high", w.host_high, out_tdata[69:6]);
    compare_field("host_low", w.host_low, out_tdata[133:70]);
    compare_field("pending_echoes", unsigned'(w.echoes), out_tdata[141:134]);
    compare_field("entries_in_use", w.in_use, out_tdata[147:142]);
    compare_field("padding", '0, out_tdata[151:148]);
    compare_field("last", w.last, out_tlast);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hosts = 0;
      for (int i = 0; i < CAPACITY; i++) table_echoes[i] = '0;
      awaited_words.delete();
      fail_count  = 0;
      check_count = 0;
      seen_mask   = '0;
    end else begin
      // a result word taken on the same edge belongs to an older command
      if (in_tvalid && in_tready) apply_command(in_tuser, in_tdata[63:0], in_tdata[127:64]);
      if (out_tvalid && out_tready) begin
        check_result();
        check_count++;
        if (out_tuser <= ST_DONE) seen_mask[out_tuser] = 1'b1;
      end
    end
    mismatches    <= fail_count;
    words_pending <= awaited_words.size();
    words_checked <= check_count;
    status_seen   <= seen_mask;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top of the heartbeat_host_table testbench
// Drives directed and random command words with random gaps and output
// stalls, runs a counter into its upper limit, fills the table past its
// capacity, churns it and thins it out again; host_table_checker does the
// checking.
// ----------------------------------------------------------------------------
module tb;
  import hht_pkg::*;

  // the quiet limit lies far above the longest correct quiet stretch
  localparam int         QUIET_LIMIT = 3000;
  localparam int         TAIL_CYCLES = 64;
  localparam int         POOL_SIZE   = 40;
  localparam int         FILL_HOSTS  = 36;
  localparam int         DRAIN_HOSTS = 25;
  localparam logic [2:0] CMD_UNUSED  = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  int unsigned mismatches;
  int unsigned words_pending;
  int unsigned words_checked;
  logic [8:0]  status_seen;
  int unsigned commands_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_wait = 0;
  bit          source_calm = 1'b0;
  bit          sink_calm = 1'b0;
  logic [127:0] host_pool [POOL_SIZE];

  always #10 clk = ~clk;

  heartbeat_host_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  host_table_checker table_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .mismatches    (mismatches),
    .words_pending (words_pending),
    .words_checked (words_checked),
    .status_seen   (status_seen)
  );

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [HALF_W-1:0] rand_half();
    return {$urandom, $urandom};
  endfunction

  // mostly pool hosts so that lookups hit, now and then a stranger
  function automatic logic [127:0] pick_host();
    if ($urandom_range(0, 9) == 0) return {rand_half(), rand_half()};
    return host_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [2:0] pick_command(int unsigned w_add, w_remove, w_ping,
                                              w_add_ping, w_reply, w_sweep, w_list);
    int unsigned r;
    r = $urandom_range(0, w_add + w_remove + w_ping + w_add_ping + w_reply + w_sweep
                          + w_list - 1);
    if (r < w_add) return CMD_ADD;
    r -= w_add;
    if (r < w_remove) return CMD_REMOVE;
    r -= w_remove;
    if (r < w_ping) return CMD_PING;
    r -= w_ping;
    if (r < w_add_ping) return CMD_ADD_PING;
    r -= w_add_ping;
    if (r < w_reply) return CMD_REPLY;
    r -= w_reply;
    if (r < w_sweep) return CMD_SWEEP;
    return CMD_LIST;
  endfunction

  // host is {address_high, address_low}
  task automatic send_command(input logic [2:0] cmd, input logic [127:0] host);
    int unsigned gap;
    if ($urandom_range(0, 29) == 0) source_calm = !source_calm;
    gap = draw_gap(source_calm);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {host[63:0], host[127:64]};
    do @(posedge clk); while (!in_tready);
    commands_sent++;
  endtask

  // result side may stall after each word, with no stalls in calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_wait = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
        sink_wait = draw_gap(sink_calm);
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      out_tready <= (sink_wait == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: no word moved for %0d cycles, %0d result words outstanding",
                 QUIET_LIMIT, words_pending);
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic [127:0] h_zero, h_ones, h_alt, h_edge, h_rand, h_sat;
    host_pool[0] = '0;
    host_pool[1] = '1;
    // odd entries above index 1 differ from the entry before them in a single bit
    for (int k = 2; k < POOL_SIZE; k++) begin
      if (k % 2) host_pool[k] = host_pool[k-1] ^ (128'd1 << $urandom_range(0, 127));
      else host_pool[k] = {rand_half(), rand_half()};
    end
    h_zero = '0;
    h_ones = '1;
    h_alt  = {64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa};
    h_edge = {64'h8000_0000_0000_0001, 64'h0000_0000_0000_8000};
    h_rand = {rand_half(), rand_half()};
    h_sat  = {rand_half(), rand_half()};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, misses, inserts, duplicates, pings, replies, compaction, sweep, list and an unused command
    send_command(CMD_LIST, h_zero);
    send_command(CMD_SWEEP, h_zero);
    send_command(CMD_REMOVE, h_zero);
    send_command(CMD_PING, h_zero);
    send_command(CMD_ADD, h_zero);
    send_command(CMD_ADD, h_zero);
    send_command(CMD_ADD, h_ones);
    send_command(CMD_ADD, h_alt);
    send_command(CMD_ADD_PING, h_edge);
    send_command(CMD_ADD_PING, h_edge);
    send_command(CMD_PING, h_ones);
    send_command(CMD_REPLY, h_alt);
    send_command(CMD_REPLY, h_rand);
    send_command(CMD_LIST, h_zero);
    send_command(CMD_REMOVE, h_ones);
    send_command(CMD_LIST, h_zero);
    send_command(CMD_SWEEP, h_zero);
    send_command(CMD_SWEEP, h_zero);
    send_command(CMD_UNUSED, h_ones);
    send_command(CMD_REMOVE, h_zero);
    send_command(CMD_REMOVE, h_rand);

    // one host counted up to its limit and one step past it
    send_command(CMD_ADD_PING, h_sat);
    repeat (127) send_command($urandom_range(0, 1) ? CMD_PING : CMD_ADD_PING, h_sat);
    send_command(CMD_LIST, h_sat);
    send_command(CMD_SWEEP, h_sat);

    // fill past capacity, churn, then remove most of the pool again
    for (int k = 0; k < FILL_HOSTS; k++) send_command(CMD_ADD, host_pool[k]);
    repeat (20) send_command(pick_command(14, 14, 18, 18, 20, 8, 8), pick_host());
    for (int k = 0; k < DRAIN_HOSTS; k++) send_command(CMD_REMOVE, host_pool[k]);
    send_command(CMD_LIST, h_zero);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d command words sent, %0d result words checked, %0d mismatches",
             commands_sent, words_checked, mismatches);
    $display("tb: result statuses seen, done down to added: %b", status_seen);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
